// ===== src/sliding_window_rate_monitor_core_defines.svh =====
`ifndef SLIDING_WINDOW_RATE_MONITOR_CORE_DEFINES_SVH
`define SLIDING_WINDOW_RATE_MONITOR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SWRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define SWRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/swrm_pkg.sv =====
`default_nettype none

package swrm_pkg;

    // Event time store geometry (depth must be a power of two)
    localparam int FIFO_DEPTH = 64;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Time base and register widths
    localparam int TIME_BITS  = 32;
    localparam int WIN_W      = 31;
    localparam int THR_W      = 7;
    localparam int CFG_W      = 31;
    localparam int CFG_ADDR_W = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000);

    // Packed result width, padded to whole bytes
    localparam int LEVEL_W  = 2;
    localparam int RES_W    = LEVEL_W + CNT_W + 2;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_TICKS = 2'd0,
        REG_WARN_COUNT   = 2'd1,
        REG_ERROR_COUNT  = 2'd2,
        REG_FATAL_COUNT  = 2'd3
    } cfg_reg_t;

    // Health levels
    typedef enum logic [LEVEL_W-1:0] {
        LVL_OK    = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ERROR = 2'd2,
        LVL_FATAL = 2'd3
    } level_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // take the accepted transaction
        logic pop;     // drop the oldest stored time
        logic append;  // store the event and update readiness
        logic emit;    // load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic expire_hit;  // oldest stored time has left the window
        logic out_free;    // result register can take a new result
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/swrm_ctrl.sv =====
`default_nettype none
`include "sliding_window_rate_monitor_core_defines.svh"

module swrm_ctrl
    import swrm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPIRE = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Sequence one transaction: take, expire, append, report
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                if (sts.expire_hit) begin
                    cmd.pop = 1'b1;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SWRM_ASSERT_NOW(a_cmd_single, 1'b1, $onehot0(cmd), "more than one datapath command")
    `SWRM_ASSERT_NEXT(a_load_leaves_idle, cmd.load, !s_tready,
                      "input taken again before the transaction was finished")

endmodule

`default_nettype wire

// ===== src/swrm_dp.sv =====
`default_nettype none
`include "sliding_window_rate_monitor_core_defines.svh"

module swrm_dp
    import swrm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // input transaction payload
    input  wire logic [TIME_BITS-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    // controller link
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts
);

    // Configuration registers
    logic [WIN_W-1:0] window_ticks_reg;
    logic [THR_W-1:0] warn_count_reg;
    logic [THR_W-1:0] error_count_reg;
    logic [THR_W-1:0] fatal_count_reg;

    // Transaction registers
    logic [TIME_BITS-1:0] now_reg;
    logic                 ev_reg;
    logic                 ovf_reg;

    // Window state
    logic [TIME_BITS-1:0] start_reg;
    logic                 started_reg;
    logic                 ready_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // Event time store
    logic [TIME_BITS-1:0] mem [FIFO_DEPTH];
    logic [TIME_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;

    // Result register
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [TIME_BITS-1:0] win_eff;
    logic [TIME_BITS-1:0] age_head;
    logic [TIME_BITS-1:0] age_start;
    logic                 full;
    level_t               level;

    // Treat a zero window as one tick
    assign win_eff = (window_ticks_reg == '0) ? TIME_BITS'(1) : TIME_BITS'(window_ticks_reg);

    // Modular ages against the oldest stored time and the start time
    assign age_head  = now_reg - rdata_reg;
    assign age_start = now_reg - start_reg;
    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));

    assign sts.expire_hit = (count_reg != '0) && (age_head >= win_eff);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ticks_reg <= WINDOW_RESET;
            warn_count_reg   <= '0;
            error_count_reg  <= '0;
            fatal_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WINDOW_TICKS: window_ticks_reg <= cfg_wdata[WIN_W-1:0];
                REG_WARN_COUNT:   warn_count_reg   <= cfg_wdata[THR_W-1:0];
                REG_ERROR_COUNT:  error_count_reg  <= cfg_wdata[THR_W-1:0];
                REG_FATAL_COUNT:  fatal_count_reg  <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the ring: pop from the head, append at the tail or over the head when full
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        wr_addr    = head_reg + count_reg[IDX_W-1:0];
        if (cmd.pop) begin
            head_next  = head_reg + IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.append && ev_reg) begin
            mem_we = 1'b1;
            if (full) begin
                wr_addr   = head_reg;
                head_next = head_reg + IDX_W'(1);
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Store event times; read ahead at the next head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= now_reg;
        end
        rdata_reg <= mem[head_next];
    end

    // Hold window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            started_reg <= 1'b0;
            ready_reg   <= 1'b0;
            start_reg   <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.load && !started_reg) begin
                start_reg   <= s_tdata;
                started_reg <= 1'b1;
            end
            if (cmd.append && (age_start >= win_eff)) begin
                ready_reg <= 1'b1;
            end
        end
    end

    // Capture the transaction and its overflow flag
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg <= s_tdata;
            ev_reg  <= s_tuser;
            ovf_reg <= 1'b0;
        end else if (cmd.append && ev_reg && full) begin
            ovf_reg <= 1'b1;
        end
    end

    // Grade the stored count: error until the window is ready, then fatal, then error, then warn
    always_comb begin
        if (!ready_reg) begin
            level = LVL_ERROR;
        end else if (count_reg < CNT_W'(fatal_count_reg)) begin
            level = LVL_FATAL;
        end else if (count_reg < CNT_W'(error_count_reg)) begin
            level = LVL_ERROR;
        end else if (count_reg < CNT_W'(warn_count_reg)) begin
            level = LVL_WARN;
        end else begin
            level = LVL_OK;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_DATA_W'({ovf_reg, ready_reg, count_reg, level});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SWRM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH),
                     "stored count above store depth")
    `SWRM_ASSERT_NEXT(a_pop_count, cmd.pop, count_reg == $past(count_reg) - CNT_W'(1),
                      "pop did not drop exactly one entry")
    `SWRM_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid_reg,
                      "result not presented after emit")
    `SWRM_ASSERT_NOW(a_ovf_full, cmd.emit && ovf_reg, count_reg == CNT_W'(FIFO_DEPTH),
                     "overflow reported with room left in the store")

endmodule

`default_nettype wire

// ===== src/sliding_window_rate_monitor_core.sv =====
// Sliding-window event rate monitor. Each input transaction carries a 32-bit tick timestamp
// (s_tdata) and an event flag (s_tuser); it yields exactly one result transaction with the
// health level, the number of events inside the window, the window-ready flag and an
// overflow flag. Up to 64 event times are kept in a ring store with one read and one write
// port; entries whose modular age reaches window_ticks are dropped from the oldest end,
// one per cycle, before the new event is stored. A transaction runs through take, expire,
// append and result steps, where the expire step drops the entries that expire on it (0 to
// 64), one stored time per cycle; a result still waiting on m_tready holds the block only
// at its final step. No clearing pass is needed after reset. Write registers (window_ticks,
// warn_count, error_count, fatal_count at indexes 0 to 3) only while no transaction is in
// flight.
`default_nettype none

module sliding_window_rate_monitor_core
    import swrm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TIME_BITS-1:0]  s_tdata,   // [31:0] timestamp
    input  wire logic                  s_tuser,   // [0] event_req
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata    // [1:0] level, [8:2] window_count,
                                                  // [9] window_ready, [10] overflow
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    swrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swrm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== verif/tb_sliding_window_rate_monitor_core.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_rate_monitor_core
    import swrm_pkg::*;
();

    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 80;    // margin for the worst transaction, with 64 expiries
    localparam int TIMEOUT_NS   = 10_000_000;

    // One health report, with the fields that the result channel carries
    typedef struct packed {
        level_t           level;
        logic [CNT_W-1:0] count;
        logic             ready;
        logic             overflow;
    } rate_report_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TIME_BITS-1:0]  s_tdata;   // [31:0] timestamp
    logic                  s_tuser;   // [0] event_req
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // [1:0] level, [8:2] window_count,
                                      // [9] window_ready, [10] overflow

    // Mirror of the registers and of the event time store
    logic [WIN_W-1:0]     window_reg;
    logic [THR_W-1:0]     warn_reg;
    logic [THR_W-1:0]     error_reg;
    logic [THR_W-1:0]     fatal_reg;
    logic [TIME_BITS-1:0] event_ring [FIFO_DEPTH];
    logic [IDX_W-1:0]     ring_head;
    int                   ring_fill;
    logic [TIME_BITS-1:0] start_tick;
    logic                 start_seen;
    logic                 window_full;

    rate_report_t         reports_due [$];
    logic [TIME_BITS-1:0] now_tick;
    int tx_gap_max;
    int rx_gap_max;
    int rx_wait;
    int rx_hold;
    int fail_count;
    int sent_count;
    int checked_count;
    int overflow_count;
    int level_hits [4];

    sliding_window_rate_monitor_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the mirror by one accepted sample and return the report it yields
    function automatic rate_report_t compute_rate_report(input logic [TIME_BITS-1:0] now,
                                                         input logic event_req);
        logic [TIME_BITS-1:0] span;
        rate_report_t         rep;
        span = (window_reg == '0) ? TIME_BITS'(1) : TIME_BITS'(window_reg);
        if (!start_seen) begin
            start_tick = now;
            start_seen = 1'b1;
        end
        // drop stored times that have aged out, oldest first
        while (ring_fill > 0 && TIME_BITS'(now - event_ring[ring_head]) >= span) begin
            ring_head = ring_head + 1'b1;
            ring_fill--;
        end
        // store the event, overwriting the oldest one when full
        rep.overflow = 1'b0;
        if (event_req) begin
            if (ring_fill == FIFO_DEPTH) begin
                event_ring[ring_head] = now;
                ring_head    = ring_head + 1'b1;
                rep.overflow = 1'b1;
            end else begin
                event_ring[IDX_W'(ring_head + ring_fill)] = now;
                ring_fill++;
            end
        end
        // readiness sticks once a full window has passed
        if (TIME_BITS'(now - start_tick) >= span)
            window_full = 1'b1;
        if (!window_full)
            rep.level = LVL_ERROR;
        else if (ring_fill < fatal_reg)
            rep.level = LVL_FATAL;
        else if (ring_fill < error_reg)
            rep.level = LVL_ERROR;
        else if (ring_fill < warn_reg)
            rep.level = LVL_WARN;
        else
            rep.level = LVL_OK;
        rep.count = CNT_W'(ring_fill);
        rep.ready = window_full;
        return rep;
    endfunction

    // Offer one sample after a random gap; entered and left at a falling edge
    task automatic send_sample(input logic [TIME_BITS-1:0] ts, input logic ev);
        int           gap;
        rate_report_t due;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= ts;
        s_tuser  <= ev;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        due = compute_rate_report(ts, ev);
        reports_due.insert(reports_due.size(), due);
        sent_count++;
        now_tick = ts;
        @(negedge aclk);
    endtask

    // Hold the input idle until every report is in and the block has settled
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write all four registers while idle; junk above the threshold width is ignored
    task automatic write_settings(input logic [WIN_W-1:0] win, input logic [THR_W-1:0] warn,
                                  input logic [THR_W-1:0] err, input logic [THR_W-1:0] fat);
        cfg_reg_t         reg_order [4];
        logic [CFG_W-1:0] reg_value [4];
        drain_reports();
        reg_order = '{REG_WINDOW_TICKS, REG_WARN_COUNT, REG_ERROR_COUNT, REG_FATAL_COUNT};
        reg_value = '{win,
                      {(CFG_W-THR_W)'($urandom), warn},
                      {(CFG_W-THR_W)'($urandom), err},
                      {(CFG_W-THR_W)'($urandom), fat}};
        foreach (reg_order[i]) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= reg_order[i];
            cfg_wdata <= reg_value[i];
            @(negedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        window_reg = win;
        warn_reg   = warn;
        error_reg  = err;
        fatal_reg  = fat;
    endtask

    // Start-up with reset settings, across the time wrap, up to the window edge
    task automatic test_startup();
        logic [TIME_BITS-1:0] origin;
        origin = '1 - 32'd15;
        send_sample(origin, 1'b1);
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_sample(origin + 21, 1'b0);
        send_sample(origin + WINDOW_RESET - 1, 1'b0);
        send_sample(origin + WINDOW_RESET, 1'b1);
    endtask

    // Walk the count through the fatal, error, warn and ok bands, then expire all
    task automatic test_levels();
        logic [TIME_BITS-1:0] base;
        write_settings(WIN_W'(1000), THR_W'(6), THR_W'(4), THR_W'(2));
        base = now_tick + 5000;
        for (int i = 0; i < 7; i++)
            send_sample(base + i, 1'b1);
        send_sample(base + 1006, 1'b0);
    endtask

    // Zero window, repeated timestamps, time stepping back, widest window
    task automatic test_time_corners();
        logic [TIME_BITS-1:0] t;
        write_settings('0, '0, '0, '0);
        t = now_tick + 10;
        send_sample(t, 1'b1);
        send_sample(t, 1'b1);
        send_sample(t + 1, 1'b1);
        send_sample(t - 9, 1'b1);
        write_settings('1, '1, '1, '1);
        t = now_tick + 100;
        send_sample(t, 1'b1);
        send_sample(t + 32'h7FFF_FFFE, 1'b0);
        send_sample(t + 32'h7FFF_FFFF, 1'b1);
    endtask

    // Fill the store past its depth so the oldest times get overwritten
    task automatic test_overflow();
        logic [TIME_BITS-1:0] t;
        write_settings('1, '0, '0, '0);
        t = now_tick + 1;
        for (int i = 0; i < 72; i++) begin
            t = t + $urandom_range(0, 3);
            send_sample(t, (i < 70) ? 1'b1 : 1'b0);
        end
    endtask

    // Stall the result side for a long stretch while samples keep coming
    task automatic test_backpressure();
        logic [TIME_BITS-1:0] t;
        write_settings(WIN_W'(200), THR_W'(40), THR_W'(20), THR_W'(5));
        tx_gap_max = 0;
        rx_hold    = 400;
        t = now_tick;
        for (int i = 0; i < 24; i++) begin
            t = t + $urandom_range(0, 12);
            send_sample(t, 1'($urandom_range(0, 1)));
        end
        tx_gap_max = MAX_GAP;
    endtask

    // Random phases over a spread of windows, thresholds and idling patterns
    task automatic test_random();
        logic [WIN_W-1:0]     win;
        logic [TIME_BITS-1:0] t;
        longint               span;
        longint               step_max;
        for (int phase = 0; phase < 14; phase++) begin
            case (phase % 5)
                0:       win = WIN_W'($urandom_range(1, 64));
                1:       win = WIN_W'($urandom_range(100, 5000));
                2:       win = '1;
                3:       win = '0;
                default: win = WIN_W'($urandom);
            endcase
            if (phase == 0)
                write_settings(win, '0, '0, '0);
            else if (phase == 1)
                write_settings(win, '1, '1, '1);
            else
                write_settings(win, THR_W'($urandom_range(0, 72)),
                               THR_W'($urandom_range(0, 72)), THR_W'($urandom_range(0, 72)));
            case ($urandom_range(0, 3))
                0: begin
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                end
                1: begin
                    tx_gap_max = MAX_GAP;
                    rx_gap_max = 0;
                end
                2: begin
                    tx_gap_max = 0;
                    rx_gap_max = MAX_GAP;
                end
                default: begin
                    tx_gap_max = MAX_GAP;
                    rx_gap_max = MAX_GAP;
                end
            endcase
            span     = (win == '0) ? 1 : win;
            step_max = span / $urandom_range(8, 96) + 1;
            t        = now_tick;
            repeat (130) begin
                case ($urandom_range(0, 39))
                    0:       t = $urandom;
                    1:       t = t - $urandom_range(1, 1000);   // step back in time
                    2:       t = t + TIME_BITS'(span);          // land one window on
                    default: t = t + $urandom_range(0, 32'(step_max));
                endcase
                send_sample(t, $urandom_range(0, 99) < 75);
            end
        end
        tx_gap_max = MAX_GAP;
        rx_gap_max = MAX_GAP;
    endtask

    // Drive the result side ready, with long holds and per-transaction stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest outstanding report
    always @(posedge aclk) begin : check_reports
        rate_report_t got;
        rate_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.level    = level_t'(m_tdata[LEVEL_W-1:0]);
            got.count    = m_tdata[LEVEL_W +: CNT_W];
            got.ready    = m_tdata[LEVEL_W + CNT_W];
            got.overflow = m_tdata[LEVEL_W + CNT_W + 1];
            rx_wait = $urandom_range(0, rx_gap_max);
            if (reports_due.size() == 0) begin
                $error("result transaction with nothing outstanding, tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                checked_count++;
                level_hits[int'(want.level)]++;
                if (want.overflow)
                    overflow_count++;
                if (got.level !== want.level) begin
                    $error("level: expected %0d, actual %0d", want.level, got.level);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("window_count: expected %0d, actual %0d", want.count, got.count);
                    fail_count++;
                end
                if (got.ready !== want.ready) begin
                    $error("window_ready: expected %0b, actual %0b", want.ready, got.ready);
                    fail_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                    fail_count++;
                end
            end
        end
    end

    // Sequence the tests and report
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_WINDOW_TICKS;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        tx_gap_max  = MAX_GAP;
        rx_gap_max  = MAX_GAP;
        window_reg  = WINDOW_RESET;
        warn_reg    = '0;
        error_reg   = '0;
        fatal_reg   = '0;
        ring_head   = '0;
        ring_fill   = 0;
        start_tick  = '0;
        start_seen  = 1'b0;
        window_full = 1'b0;
        now_tick    = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_startup();
        test_levels();
        test_time_corners();
        test_overflow();
        test_backpressure();
        test_random();
        drain_reports();

        $display("Covered %0d samples, %0d reports checked, %0d overflowing events",
                 sent_count, checked_count, overflow_count);
        $display("Levels reported: ok %0d, warn %0d, error %0d, fatal %0d",
                 level_hits[int'(LVL_OK)], level_hits[int'(LVL_WARN)],
                 level_hits[int'(LVL_ERROR)], level_hits[int'(LVL_FATAL)]);
        if (fail_count == 0)
            $display("tb_sliding_window_rate_monitor_core: PASS");
        else
            $display("tb_sliding_window_rate_monitor_core: FAIL");
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d reports outstanding", reports_due.size());
        $display("tb_sliding_window_rate_monitor_core: FAIL");
        $finish;
    end

endmodule
